@@ design/pbcc_pkg.sv @@
// Shared constants, opcodes and lane/merge control types for the crossing counter.
`default_nettype none

package pbcc_pkg;

   localparam int MaxPolygons = 16;
   localparam int MaxVertices = 64;

   localparam int CoordW   = 16;
   localparam int DiffW    = CoordW + 1;
   localparam int ProdW    = 2 * DiffW;
   localparam int OpW      = 2;
   localparam int PolyIdxW = 4;
   localparam int CountW   = 5;
   localparam int VtxCntW  = $clog2(MaxVertices + 1);
   localparam int AddrW    = $clog2(MaxVertices);
   localparam int LaneIdxW = (MaxPolygons > 1) ? $clog2(MaxPolygons) : 1;

   localparam logic [CountW-1:0] CountMax = '1;

   typedef enum logic [OpW-1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_QUERY  = 2'd2
   } opcode_type;

   typedef struct packed {
      logic                     start;
      logic                     clear;
      logic                     wr_en;
      logic signed [CoordW-1:0] vertex_x;
      logic signed [CoordW-1:0] vertex_y;
   } lane_cmd_type;

   typedef struct packed {
      logic signed [CoordW-1:0] start_x;
      logic signed [CoordW-1:0] start_y;
      logic signed [CoordW-1:0] target_x;
      logic signed [CoordW-1:0] target_y;
   } point_pair_type;

   typedef struct packed {
      logic busy;
      logic odd_s;
      logic odd_t;
   } lane_stat_type;

   typedef struct packed {
      logic              done;
      logic [CountW-1:0] count;
   } merge_stat_type;

endpackage

`default_nettype wire

@@ design/pbcc_if.sv @@
// Request and response channel interfaces (valid/ready handshake).
`default_nettype none

interface pbcc_req_if import pbcc_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [OpW-1:0]             opcode;
   logic [PolyIdxW-1:0]        polygon_index;
   logic signed [CoordW-1:0]   vertex_x;
   logic signed [CoordW-1:0]   vertex_y;
   logic signed [CoordW-1:0]   start_x;
   logic signed [CoordW-1:0]   start_y;
   logic signed [CoordW-1:0]   target_x;
   logic signed [CoordW-1:0]   target_y;

   modport source (
      output valid, opcode, polygon_index, vertex_x, vertex_y,
             start_x, start_y, target_x, target_y,
      input  ready
   );
   modport sink (
      input  valid, opcode, polygon_index, vertex_x, vertex_y,
             start_x, start_y, target_x, target_y,
      output ready
   );
endinterface

interface pbcc_rsp_if import pbcc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CountW-1:0] crossing_count;

   modport source (output valid, crossing_count, input ready);
   modport sink   (input valid, crossing_count, output ready);
endinterface

`default_nettype wire

@@ design/pbcc_lane.sv @@
// One polygon lane: vertex store plus a pipelined edge walker testing both query points.
`default_nettype none

module pbcc_lane import pbcc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  lane_cmd_type   cmd,
   input  point_pair_type pts,
   output lane_stat_type  stat
);

   logic signed [CoordW-1:0] mem_x [MaxVertices];
   logic signed [CoordW-1:0] mem_y [MaxVertices];

   logic [VtxCntW-1:0] count_ff;
   logic [VtxCntW-1:0] step_ff;
   logic               busy_ff;
   logic               issuing_ff;
   logic [AddrW-1:0]   rd_addr;
   logic               wr_ok;

   logic signed [CoordW-1:0] rd_x_ff, rd_y_ff, prev_x_ff, prev_y_ff;
   logic s1_valid_ff, s1_first_ff, s1_last_ff;
   logic s2_valid_ff, s2_last_ff;
   logic s2_span_s_ff, s2_span_t_ff, s2_dy_pos_ff;
   logic signed [ProdW-1:0] lhs_s_ff, rhs_s_ff, lhs_t_ff, rhs_t_ff;
   logic odd_s_ff, odd_t_ff;

   logic signed [DiffW-1:0] dx_ji, dy_ji, sx_i, sy_i, tx_i, ty_i;
   logic span_s, span_t, left_s, left_t;

   assign wr_ok = cmd.wr_en && (count_ff != VtxCntW'(MaxVertices));

   // first read fetches the closing vertex, then vertices 0..n-1 in order
   assign rd_addr = (step_ff == '0) ? AddrW'(count_ff - VtxCntW'(1))
                                     : AddrW'(step_ff - VtxCntW'(1));

   // edge from previous vertex j to current vertex i
   always_comb begin
      dx_ji = DiffW'(prev_x_ff) - DiffW'(rd_x_ff);
      dy_ji = DiffW'(prev_y_ff) - DiffW'(rd_y_ff);
      sx_i  = DiffW'(pts.start_x) - DiffW'(rd_x_ff);
      sy_i  = DiffW'(pts.start_y) - DiffW'(rd_y_ff);
      tx_i  = DiffW'(pts.target_x) - DiffW'(rd_x_ff);
      ty_i  = DiffW'(pts.target_y) - DiffW'(rd_y_ff);
      span_s = (pts.start_y < rd_y_ff && pts.start_y >= prev_y_ff) ||
               (pts.start_y >= rd_y_ff && pts.start_y < prev_y_ff);
      span_t = (pts.target_y < rd_y_ff && pts.target_y >= prev_y_ff) ||
               (pts.target_y >= rd_y_ff && pts.target_y < prev_y_ff);
   end

   // crossing lies left of the point; sign flips with edge direction
   assign left_s = s2_dy_pos_ff ? (lhs_s_ff < rhs_s_ff) : (lhs_s_ff > rhs_s_ff);
   assign left_t = s2_dy_pos_ff ? (lhs_t_ff < rhs_t_ff) : (lhs_t_ff > rhs_t_ff);

   always_ff @(posedge clock) begin
      if (wr_ok) begin
         mem_x[AddrW'(count_ff)] <= cmd.vertex_x;
         mem_y[AddrW'(count_ff)] <= cmd.vertex_y;
      end
      if (issuing_ff) begin
         rd_x_ff <= mem_x[rd_addr];
         rd_y_ff <= mem_y[rd_addr];
      end
      if (s1_valid_ff) begin
         prev_x_ff    <= rd_x_ff;
         prev_y_ff    <= rd_y_ff;
         s2_span_s_ff <= span_s;
         s2_span_t_ff <= span_t;
         s2_dy_pos_ff <= (prev_y_ff > rd_y_ff);
         lhs_s_ff     <= ProdW'(dx_ji) * ProdW'(sy_i);
         rhs_s_ff     <= ProdW'(sx_i) * ProdW'(dy_ji);
         lhs_t_ff     <= ProdW'(dx_ji) * ProdW'(ty_i);
         rhs_t_ff     <= ProdW'(tx_i) * ProdW'(dy_ji);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         step_ff     <= '0;
         busy_ff     <= 1'b0;
         issuing_ff  <= 1'b0;
         s1_valid_ff <= 1'b0;
         s1_first_ff <= 1'b0;
         s1_last_ff  <= 1'b0;
         s2_valid_ff <= 1'b0;
         s2_last_ff  <= 1'b0;
         odd_s_ff    <= 1'b0;
         odd_t_ff    <= 1'b0;
      end else begin
         if (cmd.clear) begin
            count_ff <= '0;
         end else if (wr_ok) begin
            count_ff <= count_ff + VtxCntW'(1);
         end

         if (cmd.start) begin
            busy_ff    <= (count_ff != '0);
            issuing_ff <= (count_ff != '0);
            step_ff    <= '0;
            odd_s_ff   <= 1'b0;
            odd_t_ff   <= 1'b0;
         end else if (issuing_ff) begin
            step_ff <= step_ff + VtxCntW'(1);
            if (step_ff == count_ff) begin
               issuing_ff <= 1'b0;
            end
         end

         s1_valid_ff <= issuing_ff;
         s1_first_ff <= (step_ff == '0);
         s1_last_ff  <= (step_ff == count_ff);
         s2_valid_ff <= s1_valid_ff && !s1_first_ff;
         s2_last_ff  <= s1_last_ff;

         if (s2_valid_ff) begin
            if (s2_span_s_ff && left_s) begin
               odd_s_ff <= !odd_s_ff;
            end
            if (s2_span_t_ff && left_t) begin
               odd_t_ff <= !odd_t_ff;
            end
            if (s2_last_ff) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign stat.busy  = busy_ff;
   assign stat.odd_s = odd_s_ff;
   assign stat.odd_t = odd_t_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= VtxCntW'(MaxVertices))
      else $error("lane vertex count above capacity");

   a_s2_in_walk: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> busy_ff)
      else $error("edge result outside a walk");

   a_issue_in_walk: assert property (@(posedge clock) disable iff (reset)
      issuing_ff |-> busy_ff)
      else $error("read issued while lane idle");

endmodule

`default_nettype wire

@@ design/pbcc_merge.sv @@
// Merge stage: counts lanes whose two containment results differ, one lane per cycle.
`default_nettype none

module pbcc_merge import pbcc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [MaxPolygons-1:0] diff,
   output merge_stat_type         stat
);

   logic                busy_ff;
   logic                done_ff;
   logic [LaneIdxW-1:0] idx_ff;
   logic [CountW-1:0]   count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         idx_ff   <= '0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            idx_ff   <= '0;
            count_ff <= '0;
         end else if (busy_ff) begin
            // saturating count
            if (diff[idx_ff] && count_ff != CountMax) begin
               count_ff <= count_ff + CountW'(1);
            end
            if (idx_ff == LaneIdxW'(MaxPolygons - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               idx_ff <= idx_ff + LaneIdxW'(1);
            end
         end
      end
   end

   assign stat.done  = done_ff;
   assign stat.count = count_ff;

endmodule

`default_nettype wire

@@ design/polygon_boundary_crossing_counter.sv @@
// Top level: request decode, polygon lanes, merge stage and response register.
// Clear and append complete when accepted and are accepted back to back.
// A query holds the request side through the lane walks, the merge and the response hand-off;
// a lane whose polygon is empty does not walk at all:
// each lane walks one edge a cycle, then the merge stage visits one lane a cycle.
// The response register lets the next request in while a count waits to be taken.
// Synchronous reset empties every polygon; vertex memories are not cleared.
`default_nettype none

module polygon_boundary_crossing_counter import pbcc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   pbcc_req_if.sink          req_chan,
   pbcc_rsp_if.source        rsp_chan
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_MERGE,
      ST_SEND
   } state_type;

   state_type         state_ff;
   logic              rsp_valid_ff;
   logic [CountW-1:0] rsp_count_ff;
   point_pair_type    qry_ff;

   logic acc;
   logic acc_query;
   logic merge_start;

   lane_cmd_type           lane_cmd [MaxPolygons];
   lane_stat_type          lane_stat [MaxPolygons];
   logic [MaxPolygons-1:0] lane_busy;
   logic [MaxPolygons-1:0] lane_diff;
   merge_stat_type         merge_stat;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign acc            = req_chan.valid && req_chan.ready;
   assign acc_query      = acc && (req_chan.opcode == OP_QUERY);
   assign merge_start    = (state_ff == ST_WALK) && (lane_busy == '0);

   always_ff @(posedge clock) begin
      if (acc_query) begin
         qry_ff.start_x  <= req_chan.start_x;
         qry_ff.start_y  <= req_chan.start_y;
         qry_ff.target_x <= req_chan.target_x;
         qry_ff.target_y <= req_chan.target_y;
      end
   end

   for (genvar p = 0; p < MaxPolygons; p++) begin : g_lane
      always_comb begin
         lane_cmd[p].start    = acc_query;
         lane_cmd[p].clear    = acc && (req_chan.opcode == OP_CLEAR);
         lane_cmd[p].wr_en    = acc && (req_chan.opcode == OP_APPEND) &&
                                (32'(req_chan.polygon_index) == p);
         lane_cmd[p].vertex_x = req_chan.vertex_x;
         lane_cmd[p].vertex_y = req_chan.vertex_y;
      end

      pbcc_lane u_lane (
         .clock (clock),
         .reset (reset),
         .cmd   (lane_cmd[p]),
         .pts   (qry_ff),
         .stat  (lane_stat[p])
      );

      assign lane_busy[p] = lane_stat[p].busy;
      assign lane_diff[p] = lane_stat[p].odd_s ^ lane_stat[p].odd_t;
   end

   pbcc_merge u_merge (
      .clock (clock),
      .reset (reset),
      .start (merge_start),
      .diff  (lane_diff),
      .stat  (merge_stat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rsp_count_ff <= '0;
      end else begin
         if (rsp_valid_ff && rsp_chan.ready && (state_ff != ST_SEND)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (acc_query) begin
                  state_ff <= ST_WALK;
               end
            end
            ST_WALK: begin
               if (merge_start) begin
                  state_ff <= ST_MERGE;
               end
            end
            ST_MERGE: begin
               if (merge_stat.done) begin
                  state_ff <= ST_SEND;
               end
            end
            ST_SEND: begin
               // wait for the output register to drain
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_count_ff <= merge_stat.count;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.crossing_count = rsp_count_ff;

   a_idle_lanes_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (lane_busy == '0))
      else $error("lane busy while accepting requests");

   a_merge_done_state: assert property (@(posedge clock) disable iff (reset)
      merge_stat.done |-> (state_ff == ST_MERGE))
      else $error("merge finished outside merge state");

   a_query_starts_walk: assert property (@(posedge clock) disable iff (reset)
      acc_query |=> (state_ff == ST_WALK))
      else $error("query transfer did not start a walk");

endmodule

`default_nettype wire
